// ----- rtl/cc3p_pkg.sv -----
// ----------------------------------------------------------------------------
// cc3p_pkg: shared types and constants
// Request and result payloads and the fixed widths of the circumcircle block.
// ----------------------------------------------------------------------------
`default_nettype none
package cc3p_pkg;

  localparam int FIELD_W    = 12;
  localparam int CENTER_W   = 40;
  localparam int RADIUS_W   = 39;
  localparam int TOL_W      = 8;
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [FIELD_W-1:0] first_x;
    logic [FIELD_W-1:0] first_y;
    logic [FIELD_W-1:0] second_x;
    logic [FIELD_W-1:0] second_y;
    logic [FIELD_W-1:0] third_x;
    logic [FIELD_W-1:0] third_y;
  } in_req_t;

  typedef struct packed {
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic [RADIUS_W-1:0]        radius;
    logic                       valid_res;
  } out_res_t;

endpackage
`default_nettype wire

// ----- rtl/cc3p_if.sv -----
// ----------------------------------------------------------------------------
// cc3p channel interfaces
// Valid/ready channels for requests, results and the tolerance register.
// ----------------------------------------------------------------------------
`default_nettype none
interface cc3p_in_if;
  import cc3p_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cc3p_out_if;
  import cc3p_pkg::*;
  logic     valid;
  logic     ready;
  out_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cc3p_cfg_if;
  import cc3p_pkg::*;
  logic             valid;
  logic             ready;
  logic [TOL_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/circumcircle_from_three_points_core.sv -----
// ----------------------------------------------------------------------------
// circumcircle_from_three_points_core: circle through three image points
// Intake stage, short queue and a stallable arithmetic pipeline.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch as three points; each gives exactly one result on
// out_ch with the center, the first radius and the consistency flag. cfg_ch
// writes the radius tolerance; the user must write it only while the block is
// idle, which the block does not enforce; cfg_ch is always ready. A new request
// is taken every cycle as long as the queue has room, so while out_ch keeps up
// the sustained rate is one request per cycle. Requests pass the intake register,
// queue, arithmetic stages, one-bit-per-stage divider and square root pipelines
// and output register. When out_ch stalls, the whole arithmetic pipeline holds;
// the four-entry queue and the intake register then fill before in_ch drops
// ready. Reset empties the pipeline and the queue and sets the tolerance to 3.
// ----------------------------------------------------------------------------
`default_nettype none
module circumcircle_from_three_points_core #(
  parameter int COORD_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  cc3p_in_if.sink      in_ch,
  cc3p_out_if.source   out_ch,
  cc3p_cfg_if.sink     cfg_ch
);
  import cc3p_pkg::*;

  localparam int IW = 6*COORD_BITS;

  logic [TOL_W-1:0] tol_r;
  logic             f_vld, f_rdy;
  logic [IW-1:0]    f_data;
  logic             q_vld, q_rdy;
  logic [IW-1:0]    q_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_ch.valid) begin
      tol_r <= cfg_ch.data;
    end
  end

  cc3p_front #(.N(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .item_vld (f_vld),
    .item_rdy (f_rdy),
    .item_data(f_data)
  );

  cc3p_fifo #(.W(IW)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (f_vld),
    .push_rdy (f_rdy),
    .push_data(f_data),
    .pop_vld  (q_vld),
    .pop_rdy  (q_rdy),
    .pop_data (q_data)
  );

  cc3p_back #(.N(COORD_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .pop_vld (q_vld),
    .pop_rdy (q_rdy),
    .pop_data(q_data),
    .tol     (tol_r),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ----- rtl/cc3p_front.sv -----
// ----------------------------------------------------------------------------
// cc3p_front: request intake
// Registers each request and trims or zero-extends the coordinates to the working width.
// ----------------------------------------------------------------------------
`default_nettype none
module cc3p_front #(
  parameter int N = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  cc3p_in_if.sink          in_ch,
  output logic             item_vld,
  input  logic             item_rdy,
  output logic [6*N-1:0]   item_data
);
  import cc3p_pkg::*;

  localparam int TB = (N < FIELD_W) ? N : FIELD_W;

  logic           vld_r;
  logic [6*N-1:0] data_r;
  logic           take;

  assign in_ch.ready = !vld_r || item_rdy;
  assign take        = in_ch.valid && in_ch.ready;
  assign item_vld    = vld_r;
  assign item_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (item_rdy) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= {N'(in_ch.data.first_x[TB-1:0]),  N'(in_ch.data.first_y[TB-1:0]),
                 N'(in_ch.data.second_x[TB-1:0]), N'(in_ch.data.second_y[TB-1:0]),
                 N'(in_ch.data.third_x[TB-1:0]),  N'(in_ch.data.third_y[TB-1:0])};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cc3p_fifo.sv -----
// ----------------------------------------------------------------------------
// cc3p_fifo: short request queue
// Decouples the intake from the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module cc3p_fifo #(
  parameter int W = 72
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_vld,
  output logic         push_rdy,
  input  logic [W-1:0] push_data,
  output logic         pop_vld,
  input  logic         pop_rdy,
  output logic [W-1:0] pop_data
);
  import cc3p_pkg::*;

  logic [W-1:0]       mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_push, do_pop;

  assign push_rdy = cnt_r != (FIFO_AW+1)'(FIFO_DEPTH);
  assign pop_vld  = cnt_r != '0;
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ----- rtl/cc3p_div.sv -----
// ----------------------------------------------------------------------------
// cc3p_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, several numerators
// sharing one divisor, with a sideband carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none
module cc3p_div #(
  parameter int NUMW  = 8,
  parameter int DENW  = 8,
  parameter int LANES = 2,
  parameter int SBW   = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [NUMW-1:0] num_i [LANES],
  input  logic [DENW-1:0] den_i,
  input  logic [SBW-1:0]  sb_i,
  output logic            out_vld,
  output logic [NUMW-1:0] quo_o [LANES],
  output logic [SBW-1:0]  sb_o
);

  logic            vld_r [NUMW];
  logic [DENW-1:0] rem_r [NUMW][LANES];
  logic [NUMW-1:0] nq_r  [NUMW][LANES];
  logic [DENW-1:0] den_r [NUMW];
  logic [SBW-1:0]  sb_r  [NUMW];

  for (genvar k = 0; k < NUMW; k++) begin : g_stg
    logic            vld_c;
    logic [DENW-1:0] rem_c [LANES];
    logic [NUMW-1:0] nq_c  [LANES];
    logic [DENW-1:0] den_c;
    logic [SBW-1:0]  sb_c;
    logic [DENW-1:0] rem_nxt [LANES];
    logic [NUMW-1:0] nq_nxt  [LANES];

    if (k == 0) begin : g_head
      always_comb begin
        vld_c = in_vld;
        den_c = den_i;
        sb_c  = sb_i;
        for (int l = 0; l < LANES; l++) begin
          rem_c[l] = '0;
          nq_c[l]  = num_i[l];
        end
      end
    end else begin : g_body
      always_comb begin
        vld_c = vld_r[k-1];
        den_c = den_r[k-1];
        sb_c  = sb_r[k-1];
        for (int l = 0; l < LANES; l++) begin
          rem_c[l] = rem_r[k-1][l];
          nq_c[l]  = nq_r[k-1][l];
        end
      end
    end

    // The numerator shifts out at the top while quotient bits enter below.
    always_comb begin : p_step
      logic [DENW:0] sh;
      logic [DENW:0] df;
      for (int l = 0; l < LANES; l++) begin
        sh = {rem_c[l], nq_c[l][NUMW-1]};
        df = sh - {1'b0, den_c};
        if (df[DENW]) begin
          rem_nxt[l] = sh[DENW-1:0];
          nq_nxt[l]  = {nq_c[l][NUMW-2:0], 1'b0};
        end else begin
          rem_nxt[l] = df[DENW-1:0];
          nq_nxt[l]  = {nq_c[l][NUMW-2:0], 1'b1};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_c;
        sb_r[k]  <= sb_c;
        for (int l = 0; l < LANES; l++) begin
          rem_r[k][l] <= rem_nxt[l];
          nq_r[k][l]  <= nq_nxt[l];
        end
      end
    end
  end

  assign out_vld = vld_r[NUMW-1];
  assign sb_o    = sb_r[NUMW-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) quo_o[l] = nq_r[NUMW-1][l];
  end

endmodule
`default_nettype wire

// ----- rtl/cc3p_isqrt.sv -----
// ----------------------------------------------------------------------------
// cc3p_isqrt: pipelined integer square root
// Digit-by-digit floor square root, one root bit per stage, several lanes.
// ----------------------------------------------------------------------------
`default_nettype none
module cc3p_isqrt #(
  parameter int RW    = 8,
  parameter int LANES = 3,
  parameter int SBW   = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [2*RW-1:0] rad_i [LANES],
  input  logic [SBW-1:0]  sb_i,
  output logic            out_vld,
  output logic [RW-1:0]   root_o [LANES],
  output logic [SBW-1:0]  sb_o
);

  logic            vld_r  [RW];
  logic [RW:0]     rem_r  [RW][LANES];
  logic [RW-1:0]   root_r [RW][LANES];
  logic [2*RW-1:0] rad_r  [RW][LANES];
  logic [SBW-1:0]  sb_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stg
    logic            vld_c;
    logic [RW:0]     rem_c  [LANES];
    logic [RW-1:0]   root_c [LANES];
    logic [2*RW-1:0] rad_c  [LANES];
    logic [SBW-1:0]  sb_c;
    logic [RW:0]     rem_nxt  [LANES];
    logic [RW-1:0]   root_nxt [LANES];

    if (k == 0) begin : g_head
      always_comb begin
        vld_c = in_vld;
        sb_c  = sb_i;
        for (int l = 0; l < LANES; l++) begin
          rem_c[l]  = '0;
          root_c[l] = '0;
          rad_c[l]  = rad_i[l];
        end
      end
    end else begin : g_body
      always_comb begin
        vld_c = vld_r[k-1];
        sb_c  = sb_r[k-1];
        for (int l = 0; l < LANES; l++) begin
          rem_c[l]  = rem_r[k-1][l];
          root_c[l] = root_r[k-1][l];
          rad_c[l]  = rad_r[k-1][l];
        end
      end
    end

    // Bring down two radicand bits and try the trial divisor 4*root+1.
    always_comb begin : p_step
      logic [RW+2:0] sh;
      logic [RW+3:0] df;
      for (int l = 0; l < LANES; l++) begin
        sh = {rem_c[l], rad_c[l][2*RW-1 -: 2]};
        df = {1'b0, sh} - {2'b00, root_c[l], 2'b01};
        if (df[RW+3]) begin
          rem_nxt[l]  = sh[RW:0];
          root_nxt[l] = {root_c[l][RW-2:0], 1'b0};
        end else begin
          rem_nxt[l]  = df[RW:0];
          root_nxt[l] = {root_c[l][RW-2:0], 1'b1};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[k] <= sb_c;
        for (int l = 0; l < LANES; l++) begin
          rem_r[k][l]  <= rem_nxt[l];
          root_r[k][l] <= root_nxt[l];
          rad_r[k][l]  <= {rad_c[l][2*RW-3:0], 2'b00};
        end
      end
    end
  end

  assign out_vld = vld_r[RW-1];
  assign sb_o    = sb_r[RW-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) root_o[l] = root_r[RW-1][l];
  end

endmodule
`default_nettype wire

// ----- rtl/cc3p_back.sv -----
// ----------------------------------------------------------------------------
// cc3p_back: circumcircle arithmetic pipeline
// Determinant form, center division, three radii and the consistency check.
// All stages advance together whenever the output register can take data.
// ----------------------------------------------------------------------------
`default_nettype none
module cc3p_back #(
  parameter int N = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pop_vld,
  output logic                      pop_rdy,
  input  logic [6*N-1:0]            pop_data,
  input  logic [cc3p_pkg::TOL_W-1:0] tol,
  cc3p_out_if.source                out_ch
);
  import cc3p_pkg::*;

  localparam int AW   = N + 1;
  localparam int PW   = 2*N + 3;
  localparam int GPW  = 2*N + 2;
  localparam int EW   = 2*N + 4;
  localparam int GW   = 2*N + 4;
  localparam int DEW  = 3*N + 5;
  localparam int XW   = 3*N + 6;
  localparam int CW   = XW + 1;
  localparam int MW   = CW + 1;
  localparam int H    = (MW + 1) / 2;
  localparam int SQW  = 4*H;
  localparam int RW   = MW + 1;
  localparam int RADW = 2*RW;
  localparam int CRDW = 6*N;

  logic         en;
  logic [14:1]  v_r;
  logic         out_vld_r;
  out_res_t     out_data_r;

  assign en         = !out_vld_r || out_ch.ready;
  assign pop_rdy    = en;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  // Stage 1: coordinate differences and sums.
  logic [N-1:0] px [3];
  logic [N-1:0] py [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      px[i] = pop_data[(5-2*i)*N +: N];
      py[i] = pop_data[(4-2*i)*N +: N];
    end
  end

  logic signed [AW-1:0] a1_r, b1_r, c1_r, d1_r, u1_r, w1_r;
  logic [AW-1:0]        s12x_r, s12y_r, s13x_r, s13y_r;
  logic [CRDW-1:0]      crd1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= $signed({1'b0, px[1]}) - $signed({1'b0, px[0]});
      b1_r   <= $signed({1'b0, py[1]}) - $signed({1'b0, py[0]});
      c1_r   <= $signed({1'b0, px[2]}) - $signed({1'b0, px[0]});
      d1_r   <= $signed({1'b0, py[2]}) - $signed({1'b0, py[0]});
      u1_r   <= $signed({1'b0, py[2]}) - $signed({1'b0, py[1]});
      w1_r   <= $signed({1'b0, px[2]}) - $signed({1'b0, px[1]});
      s12x_r <= AW'(px[0]) + AW'(px[1]);
      s12y_r <= AW'(py[0]) + AW'(py[1]);
      s13x_r <= AW'(px[0]) + AW'(px[2]);
      s13y_r <= AW'(py[0]) + AW'(py[2]);
      crd1_r <= pop_data;
    end
  end

  // Stage 2: first products.
  logic signed [PW-1:0]  pa2_r, pb2_r, pc2_r, pd2_r;
  logic signed [GPW-1:0] pg2a_r, pg2b_r;
  logic signed [AW-1:0]  a2_r, b2_r, c2_r, d2_r;
  logic [CRDW-1:0]       crd2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pa2_r  <= a1_r * $signed({1'b0, s12x_r});
      pb2_r  <= b1_r * $signed({1'b0, s12y_r});
      pc2_r  <= c1_r * $signed({1'b0, s13x_r});
      pd2_r  <= d1_r * $signed({1'b0, s13y_r});
      pg2a_r <= a1_r * u1_r;
      pg2b_r <= b1_r * w1_r;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      c2_r   <= c1_r;
      d2_r   <= d1_r;
      crd2_r <= crd1_r;
    end
  end

  // Stage 3: E, F and the doubled determinant G.
  logic signed [EW-1:0] e3_r, f3_r;
  logic signed [GW-1:0] g3_r;
  logic signed [AW-1:0] a3_r, b3_r, c3_r, d3_r;
  logic [CRDW-1:0]      crd3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      e3_r   <= EW'(pa2_r) + EW'(pb2_r);
      f3_r   <= EW'(pc2_r) + EW'(pd2_r);
      g3_r   <= {(GW-1)'(pg2a_r) - (GW-1)'(pg2b_r), 1'b0};
      a3_r   <= a2_r;
      b3_r   <= b2_r;
      c3_r   <= c2_r;
      d3_r   <= d2_r;
      crd3_r <= crd2_r;
    end
  end

  // Stage 4: numerator products.
  logic signed [DEW-1:0] de4_r, bf4_r, af4_r, ce4_r;
  logic signed [GW-1:0]  g4_r;
  logic [CRDW-1:0]       crd4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      de4_r  <= d3_r * e3_r;
      bf4_r  <= b3_r * f3_r;
      af4_r  <= a3_r * f3_r;
      ce4_r  <= c3_r * e3_r;
      g4_r   <= g3_r;
      crd4_r <= crd3_r;
    end
  end

  // Stage 5: numerators.
  logic signed [XW-1:0] nx5_r, ny5_r;
  logic signed [GW-1:0] g5_r;
  logic [CRDW-1:0]      crd5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      nx5_r  <= XW'(de4_r) - XW'(bf4_r);
      ny5_r  <= XW'(af4_r) - XW'(ce4_r);
      g5_r   <= g4_r;
      crd5_r <= crd4_r;
    end
  end

  // Stage 6: magnitudes and quotient signs; the division truncates toward zero.
  logic [XW-1:0]   mx6_r, my6_r;
  logic [GW-1:0]   mg6_r;
  logic            negx6_r, negy6_r, gz6_r;
  logic [CRDW-1:0] crd6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      mx6_r   <= nx5_r[XW-1] ? XW'(-nx5_r) : XW'(nx5_r);
      my6_r   <= ny5_r[XW-1] ? XW'(-ny5_r) : XW'(ny5_r);
      mg6_r   <= g5_r[GW-1] ? GW'(-g5_r) : GW'(g5_r);
      negx6_r <= nx5_r[XW-1] ^ g5_r[GW-1];
      negy6_r <= ny5_r[XW-1] ^ g5_r[GW-1];
      gz6_r   <= g5_r == '0;
      crd6_r  <= crd5_r;
    end
  end

  logic [XW-1:0]     div_num [2];
  logic [XW-1:0]     div_quo [2];
  logic [CRDW+2:0]   div_sb;
  logic              div_vld;

  assign div_num[0] = mx6_r;
  assign div_num[1] = my6_r;

  cc3p_div #(
    .NUMW (XW),
    .DENW (GW),
    .LANES(2),
    .SBW  (CRDW+3)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (v_r[6]),
    .num_i  (div_num),
    .den_i  (mg6_r),
    .sb_i   ({crd6_r, gz6_r, negx6_r, negy6_r}),
    .out_vld(div_vld),
    .quo_o  (div_quo),
    .sb_o   (div_sb)
  );

  // Stage 7: signed center; collinear points fall back to the first point.
  logic signed [CW-1:0] cx7_r, cy7_r;
  logic [CRDW-1:0]      crd7_r;
  logic [CRDW-1:0]      dcrd;
  assign dcrd = div_sb[CRDW+2:3];
  always_ff @(posedge clk) begin
    if (en) begin
      crd7_r <= dcrd;
      if (div_sb[2]) begin
        cx7_r <= CW'($signed({1'b0, dcrd[5*N +: N]}));
        cy7_r <= CW'($signed({1'b0, dcrd[4*N +: N]}));
      end else begin
        cx7_r <= div_sb[1] ? -$signed({1'b0, div_quo[0]}) : $signed({1'b0, div_quo[0]});
        cy7_r <= div_sb[0] ? -$signed({1'b0, div_quo[1]}) : $signed({1'b0, div_quo[1]});
      end
    end
  end

  // Stage 8: offsets of the three points from the center.
  logic signed [MW-1:0] dd8_r [6];
  logic signed [CW-1:0] cx8_r, cy8_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd8_r[2*i]   <= MW'($signed({1'b0, crd7_r[(5-2*i)*N +: N]})) - MW'(cx7_r);
        dd8_r[2*i+1] <= MW'($signed({1'b0, crd7_r[(4-2*i)*N +: N]})) - MW'(cy7_r);
      end
      cx8_r <= cx7_r;
      cy8_r <= cy7_r;
    end
  end

  // Stage 9: absolute offsets.
  logic [MW-1:0]        md9_r [6];
  logic signed [CW-1:0] cx9_r, cy9_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        md9_r[i] <= dd8_r[i][MW-1] ? MW'(-dd8_r[i]) : MW'(dd8_r[i]);
      end
      cx9_r <= cx8_r;
      cy9_r <= cy8_r;
    end
  end

  // Stage 10: each square split into half-width partial products.
  logic [2*H-1:0]       pl10_r [6];
  logic [2*H-1:0]       pm10_r [6];
  logic [2*H-1:0]       ph10_r [6];
  logic signed [CW-1:0] cx10_r, cy10_r;
  logic [H-1:0]         dlo [6];
  logic [H-1:0]         dhi [6];
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      dlo[i] = md9_r[i][H-1:0];
      dhi[i] = H'(md9_r[i][MW-1:H]);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        pl10_r[i] <= dlo[i] * dlo[i];
        pm10_r[i] <= dhi[i] * dlo[i];
        ph10_r[i] <= dhi[i] * dhi[i];
      end
      cx10_r <= cx9_r;
      cy10_r <= cy9_r;
    end
  end

  // Stage 11: assemble the squares.
  logic [SQW-1:0]       sq11_r [6];
  logic signed [CW-1:0] cx11_r, cy11_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        sq11_r[i] <= SQW'({ph10_r[i], {(2*H){1'b0}}}) + SQW'({pm10_r[i], {(H+1){1'b0}}})
                   + SQW'(pl10_r[i]);
      end
      cx11_r <= cx10_r;
      cy11_r <= cy10_r;
    end
  end

  // Stage 12: squared distances.
  logic [RADW-1:0]      rad12_r [3];
  logic signed [CW-1:0] cx12_r, cy12_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rad12_r[i] <= RADW'(sq11_r[2*i]) + RADW'(sq11_r[2*i+1]);
      end
      cx12_r <= cx11_r;
      cy12_r <= cy11_r;
    end
  end

  logic [RW-1:0]   rt [3];
  logic [2*CW-1:0] sq_sb;
  logic            sq_vld;

  cc3p_isqrt #(
    .RW   (RW),
    .LANES(3),
    .SBW  (2*CW)
  ) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (v_r[12]),
    .rad_i  (rad12_r),
    .sb_i   ({cx12_r, cy12_r}),
    .out_vld(sq_vld),
    .root_o (rt),
    .sb_o   (sq_sb)
  );

  // Stage 13: r2 + r3 against 2 * r1.
  logic [RW:0]     s13_r, t13_r;
  logic [RW-1:0]   r13_r;
  logic [2*CW-1:0] c13_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s13_r <= (RW+1)'(rt[1]) + (RW+1)'(rt[2]);
      t13_r <= {rt[0], 1'b0};
      r13_r <= rt[0];
      c13_r <= sq_sb;
    end
  end

  // Stage 14: deviation.
  logic [RW:0]     dev14_r;
  logic [RW-1:0]   r14_r;
  logic [2*CW-1:0] c14_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dev14_r <= (s13_r > t13_r) ? s13_r - t13_r : t13_r - s13_r;
      r14_r   <= r13_r;
      c14_r   <= c13_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.center_x  <= CENTER_W'($signed(c14_r[2*CW-1:CW]));
      out_data_r.center_y  <= CENTER_W'($signed(c14_r[CW-1:0]));
      out_data_r.radius    <= RADIUS_W'(r14_r);
      out_data_r.valid_res <= dev14_r <= (RW+1)'(tol);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      v_r[1]     <= pop_vld;
      v_r[6:2]   <= v_r[5:1];
      v_r[7]     <= div_vld;
      v_r[12:8]  <= v_r[11:7];
      v_r[13]    <= sq_vld;
      v_r[14]    <= v_r[13];
      out_vld_r  <= v_r[14];
    end
  end

endmodule
`default_nettype wire
